@@ sv/ahpt_pkg.sv @@
// ----------------------------------------------------------------------------
// ahpt_pkg
// Shared types, character codes and recognizer phase codes for the
// HTTP auth-param tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ahpt_pkg;

   // input word
   typedef struct packed {
      logic [7:0] ch;
      logic       text_end;
   } req_type;

   // result word
   typedef struct packed {
      logic [7:0] raw_byte;
      logic       t68_span;
      logic       emit;
      logic [7:0] content_byte;
      logic       in_value;
      logic       pair_commit;
      logic       list_stopped;
      logic       text_done;
      logic       whole_token68;
   } rsp_type;

   // character classes of one byte
   typedef struct packed {
      logic is_end;     // end flag or zero byte
      logic is_tok;     // token character
      logic is_t68;     // token68 character
      logic is_sp;      // space or tab
      logic is_eq;
      logic is_quote;
      logic is_bslash;
      logic is_comma;
      logic is_upper;
   } cls_type;

   // list recognizer phases
   localparam logic [2:0] LP_KSTART = 3'd0;
   localparam logic [2:0] LP_KEY    = 3'd1;
   localparam logic [2:0] LP_VSTART = 3'd2;
   localparam logic [2:0] LP_VTOKEN = 3'd3;
   localparam logic [2:0] LP_QUOTED = 3'd4;
   localparam logic [2:0] LP_ESC    = 3'd5;
   localparam logic [2:0] LP_AFTER  = 3'd6;
   localparam logic [2:0] LP_STOP   = 3'd7;

   // token68 recognizer phases
   localparam logic [2:0] TP_LEAD  = 3'd0;
   localparam logic [2:0] TP_BODY  = 3'd1;
   localparam logic [2:0] TP_EQ    = 3'd2;
   localparam logic [2:0] TP_TRAIL = 3'd3;
   localparam logic [2:0] TP_FAIL  = 3'd4;

   // ASCII codes
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_APOS   = 8'h27;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UZ     = 8'h5A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_GRAVE  = 8'h60;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LZ     = 8'h7A;
   localparam logic [7:0] CH_BAR    = 8'h7C;
   localparam logic [7:0] CH_TILDE  = 8'h7E;

   // lower-case offset between ASCII letters
   localparam logic [7:0] CASE_BIT  = 8'h20;

endpackage

`default_nettype wire

@@ sv/ahpt_class.sv @@
// ----------------------------------------------------------------------------
// ahpt_class
// Classifies one input byte for both recognizers.
// ----------------------------------------------------------------------------
`default_nettype none

module ahpt_class (
   input  wire logic [7:0]       ch,
   input  wire logic             text_end,
   output ahpt_pkg::cls_type     cls
);
   import ahpt_pkg::*;

   logic alnum;
   logic tok_mark;
   logic t68_mark;

   always_comb begin
      alnum = ((ch >= CH_0) && (ch <= CH_9)) ||
              ((ch >= CH_UA) && (ch <= CH_UZ)) ||
              ((ch >= CH_LA) && (ch <= CH_LZ));

      case (ch)
         CH_BANG, CH_HASH, CH_DOLLAR, CH_PCT, CH_AMP, CH_APOS, CH_STAR,
         CH_PLUS, CH_MINUS, CH_DOT, CH_CARET, CH_UNDER, CH_GRAVE, CH_BAR,
         CH_TILDE: tok_mark = 1'b1;
         default:  tok_mark = 1'b0;
      endcase

      case (ch)
         CH_MINUS, CH_DOT, CH_UNDER, CH_TILDE, CH_PLUS, CH_SLASH: begin
            t68_mark = 1'b1;
         end
         default: t68_mark = 1'b0;
      endcase

      cls.is_end    = text_end || (ch == CH_NUL);
      cls.is_tok    = alnum || tok_mark;
      cls.is_t68    = alnum || t68_mark;
      cls.is_sp     = (ch == CH_SPACE) || (ch == CH_TAB);
      cls.is_eq     = (ch == CH_EQ);
      cls.is_quote  = (ch == CH_QUOTE);
      cls.is_bslash = (ch == CH_BSLASH);
      cls.is_comma  = (ch == CH_COMMA);
      cls.is_upper  = (ch >= CH_UA) && (ch <= CH_UZ);
   end

endmodule

`default_nettype wire

@@ sv/ahpt_t68.sv @@
// ----------------------------------------------------------------------------
// ahpt_t68
// Token68 recognizer: leading spaces, token68 run, '=' run, trailing spaces.
// ----------------------------------------------------------------------------
`default_nettype none

module ahpt_t68 (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire ahpt_pkg::cls_type cls,
   output logic                   span,
   output logic                   whole
);
   import ahpt_pkg::*;

   logic [2:0] phase_ff;
   logic [2:0] phase_in;

   always_comb begin
      span     = 1'b0;
      whole    = 1'b0;
      phase_in = phase_ff;
      if (cls.is_end) begin
         whole    = (phase_ff == TP_BODY) || (phase_ff == TP_EQ) ||
                    (phase_ff == TP_TRAIL);
         phase_in = TP_LEAD;
      end else begin
         case (phase_ff)
            TP_LEAD: begin
               if (cls.is_sp) begin
                  phase_in = TP_LEAD;
               end else if (cls.is_t68) begin
                  phase_in = TP_BODY;
                  span     = 1'b1;
               end else begin
                  phase_in = TP_FAIL;
               end
            end
            TP_BODY: begin
               if (cls.is_t68) begin
                  span = 1'b1;
               end else if (cls.is_eq) begin
                  phase_in = TP_EQ;
                  span     = 1'b1;
               end else if (cls.is_sp) begin
                  phase_in = TP_TRAIL;
               end else begin
                  phase_in = TP_FAIL;
               end
            end
            TP_EQ: begin
               if (cls.is_eq) begin
                  span = 1'b1;
               end else if (cls.is_sp) begin
                  phase_in = TP_TRAIL;
               end else begin
                  phase_in = TP_FAIL;
               end
            end
            TP_TRAIL: begin
               if (!cls.is_sp) phase_in = TP_FAIL;
            end
            default: phase_in = TP_FAIL;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= TP_LEAD;
      end else if (step) begin
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/ahpt_list.sv @@
// ----------------------------------------------------------------------------
// ahpt_list
// Key=value list recognizer: emits key/value bytes, commits pairs, stops on
// the first syntax error.
// ----------------------------------------------------------------------------
`default_nettype none

module ahpt_list (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [7:0]        ch,
   input  wire ahpt_pkg::cls_type cls,
   output logic                   emit,
   output logic [7:0]             content,
   output logic                   in_value,
   output logic                   commit,
   output logic                   stopped
);
   import ahpt_pkg::*;

   logic [2:0] phase_ff;
   logic [2:0] phase_in;
   logic [7:0] lower_ch;

   assign lower_ch = cls.is_upper ? (ch | CASE_BIT) : ch;

   always_comb begin
      emit     = 1'b0;
      content  = CH_NUL;
      in_value = 1'b0;
      commit   = 1'b0;
      stopped  = 1'b0;
      phase_in = phase_ff;
      if (cls.is_end) begin
         commit   = (phase_ff == LP_VTOKEN) || (phase_ff == LP_AFTER);
         stopped  = !commit && (phase_ff != LP_KSTART);
         phase_in = LP_KSTART;
      end else begin
         case (phase_ff)
            LP_KSTART: begin
               if (cls.is_sp) begin
                  phase_in = LP_KSTART;
               end else if (cls.is_tok) begin
                  emit     = 1'b1;
                  content  = lower_ch;
                  phase_in = LP_KEY;
               end else begin
                  phase_in = LP_STOP;
               end
            end
            LP_KEY: begin
               if (cls.is_tok) begin
                  emit    = 1'b1;
                  content = lower_ch;
               end else if (cls.is_eq) begin
                  phase_in = LP_VSTART;
               end else begin
                  phase_in = LP_STOP;
               end
            end
            LP_VSTART: begin
               if (cls.is_quote) begin
                  phase_in = LP_QUOTED;
               end else if (cls.is_tok) begin
                  emit     = 1'b1;
                  in_value = 1'b1;
                  content  = ch;
                  phase_in = LP_VTOKEN;
               end else begin
                  phase_in = LP_STOP;
               end
            end
            LP_QUOTED: begin
               if (cls.is_quote) begin
                  phase_in = LP_AFTER;
               end else if (cls.is_bslash) begin
                  phase_in = LP_ESC;
               end else begin
                  emit     = 1'b1;
                  in_value = 1'b1;
                  content  = ch;
               end
            end
            LP_ESC: begin
               // escaped byte copied as is
               emit     = 1'b1;
               in_value = 1'b1;
               content  = ch;
               phase_in = LP_QUOTED;
            end
            LP_VTOKEN: begin
               if (cls.is_tok) begin
                  emit     = 1'b1;
                  in_value = 1'b1;
                  content  = ch;
               end else if (cls.is_sp) begin
                  phase_in = LP_AFTER;
               end else if (cls.is_comma) begin
                  commit   = 1'b1;
                  phase_in = LP_KSTART;
               end else begin
                  phase_in = LP_STOP;
               end
            end
            LP_AFTER: begin
               if (cls.is_sp) begin
                  phase_in = LP_AFTER;
               end else if (cls.is_comma) begin
                  commit   = 1'b1;
                  phase_in = LP_KSTART;
               end else begin
                  phase_in = LP_STOP;
               end
            end
            default: phase_in = LP_STOP;
         endcase
         stopped = (phase_in == LP_STOP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= LP_KSTART;
      end else if (step) begin
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/http_auth_param_tokenizer.sv @@
// ----------------------------------------------------------------------------
// http_auth_param_tokenizer
// Byte-serial tokenizer for an HTTP auth-param string: token68 check and
// key=value list parse side by side, one result word per input word.
// ----------------------------------------------------------------------------
//
//   channel  | ports                          | word
//   ---------+--------------------------------+-------------------------------
//   request  | req_valid  req_stall  req_data | one text byte or end flag
//   response | rsp_valid  rsp_stall  rsp_data | classified byte, pair status
//
// - One word per cycle sustained while rsp_stall stays low; a word passes
//   through the input register, then the result register. The two phase
//   registers step as a word moves into the result register.
// - reset is synchronous, active high; clears both valid bits and returns
//   the recognizers to key start and leading spaces.
// - req_stall rises only when the input register is full and the result
//   register is held by rsp_stall; both registers fill before input stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module http_auth_param_tokenizer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ahpt_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ahpt_pkg::rsp_type      rsp_data
);
   import ahpt_pkg::*;

   // input register
   logic    req_valid_ff;
   req_type req_data_ff;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   logic    rsp_free;     // result register can take a word this cycle
   logic    step;         // word moves from input to result register
   cls_type cls;

   logic       t68_span;
   logic       t68_whole;
   logic       lst_emit;
   logic [7:0] lst_content;
   logic       lst_in_value;
   logic       lst_commit;
   logic       lst_stopped;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = req_valid_ff && rsp_free;
   assign req_stall = req_valid_ff && !rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_data_ff <= req_data;
      end
   end

   ahpt_class u_class (
      .ch       (req_data_ff.ch),
      .text_end (req_data_ff.text_end),
      .cls      (cls)
   );

   ahpt_t68 u_t68 (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .cls   (cls),
      .span  (t68_span),
      .whole (t68_whole)
   );

   ahpt_list u_list (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .ch       (req_data_ff.ch),
      .cls      (cls),
      .emit     (lst_emit),
      .content  (lst_content),
      .in_value (lst_in_value),
      .commit   (lst_commit),
      .stopped  (lst_stopped)
   );

   // end-of-text word shows a zero byte
   always_comb begin
      rsp_data_in.raw_byte      = cls.is_end ? CH_NUL : req_data_ff.ch;
      rsp_data_in.t68_span      = t68_span;
      rsp_data_in.emit          = lst_emit;
      rsp_data_in.content_byte  = lst_content;
      rsp_data_in.in_value      = lst_in_value;
      rsp_data_in.pair_commit   = lst_commit;
      rsp_data_in.list_stopped  = lst_stopped;
      rsp_data_in.text_done     = cls.is_end;
      rsp_data_in.whole_token68 = t68_whole;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // end word carries no content and no token68 span
   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.text_done |->
         !rsp_data_ff.emit && !rsp_data_ff.t68_span)
      else $error("end-of-text word carries content");

   // a pair is never committed and dropped in the same word
   a_commit_xor_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.pair_commit && rsp_data_ff.list_stopped))
      else $error("pair committed on a stopped list");

   // emitted key bytes are lower case
   a_key_lower: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.emit && !rsp_data_ff.in_value |->
         !((rsp_data_ff.content_byte >= CH_UA) && (rsp_data_ff.content_byte <= CH_UZ)))
      else $error("upper-case key byte emitted");

   // a result word only appears after an input word was held
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(req_valid_ff))
      else $error("result word without input word");

endmodule

`default_nettype wire
